### sv/sip_pkg.sv
// Shared types and constants for the segment intersection point unit.
`default_nettype none
package sip_pkg;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_POINT   = 2'd1,
      ST_OVERLAP = 2'd2
   } status_type;

   localparam int POINT_BITS = 32;
   localparam int RSP_BITS   = 72;

endpackage
`default_nettype wire

### sv/sip_front.sv
// Front pipeline: differences, cross products, orientation, status and dividend products.
`default_nettype none
module sip_front #(
   parameter int C = 16
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [8*C-1:0]         coords,
   output sip_pkg::status_type         status,
   output logic signed [C-1:0]         base_x,
   output logic signed [C-1:0]         base_y,
   output logic [3*C+2:0]              prod_x,
   output logic [3*C+2:0]              prod_y,
   output logic [2*C+1:0]              den_mag,
   output logic                        neg_x,
   output logic                        neg_y,
   output logic                        den_zero
);
   localparam int D  = C + 1;
   localparam int X  = 2 * D + 1;
   localparam int RB = 2 * C + 2;

   logic signed [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;
   logic signed [D-1:0] ux_in [6], uy_in [6], wx_in [6], wy_in [6];
   logic signed [D-1:0] ux_ff [6], uy_ff [6], wx_ff [6], wy_ff [6];
   logic signed [C-1:0] ax1_ff, ay1_ff;
   logic                ovl_in, ovl1_ff;

   logic signed [2*D-1:0] pa_ff [6], pb_ff [6];
   logic signed [D-1:0]   bax2_ff, bay2_ff;
   logic signed [C-1:0]   ax2_ff, ay2_ff;
   logic                  ovl2_ff;

   logic signed [X-1:0] cr [6];
   logic [1:0]          sgn [6];
   sip_pkg::status_type st3_in, st3_ff, st4_ff;
   logic signed [X-1:0] num3_ff, den3_ff;
   logic signed [D-1:0] bax3_ff, bay3_ff;
   logic signed [C-1:0] ax3_ff, ay3_ff, ax4_ff, ay4_ff;

   logic signed [X-1:0] num_abs_s, den_abs_s;
   logic signed [D-1:0] dx_abs_s, dy_abs_s;
   logic [X-2:0]        num_mag;
   logic [D-1:0]        dx_mag, dy_mag;
   logic [3*C+2:0]      px_ff, py_ff;
   logic [RB-1:0]       ue_ff;
   logic                nx_ff, ny_ff, dz_ff;

   function automatic logic signed [D-1:0] dif(input logic signed [C-1:0] p,
                                               input logic signed [C-1:0] q);
      dif = D'(p) - D'(q);
   endfunction

   always_comb begin
      ax = coords[0*C +: C];
      ay = coords[1*C +: C];
      bx = coords[2*C +: C];
      by = coords[3*C +: C];
      cx = coords[4*C +: C];
      cy = coords[5*C +: C];
      dx = coords[6*C +: C];
      dy = coords[7*C +: C];
      ux_in[0] = dif(cx, ax); uy_in[0] = dif(cy, ay);
      wx_in[0] = dif(bx, cx); wy_in[0] = dif(by, cy);
      ux_in[1] = dif(ax, cx); uy_in[1] = dif(ay, cy);
      wx_in[1] = dif(dx, ax); wy_in[1] = dif(dy, ay);
      ux_in[2] = dif(dx, ax); uy_in[2] = dif(dy, ay);
      wx_in[2] = dif(bx, dx); wy_in[2] = dif(by, dy);
      ux_in[3] = dif(bx, cx); uy_in[3] = dif(by, cy);
      wx_in[3] = dif(dx, bx); wy_in[3] = dif(dy, by);
      ux_in[4] = dif(cx, ax); uy_in[4] = dif(cy, ay);
      wx_in[4] = dif(dx, cx); wy_in[4] = dif(dy, cy);
      ux_in[5] = dif(bx, ax); uy_in[5] = dif(by, ay);
      wx_in[5] = dif(dx, cx); wy_in[5] = dif(dy, cy);
      ovl_in = ((ax > bx ? ax : bx) >= (cx < dx ? cx : dx)) &&
               ((cx > dx ? cx : dx) >= (ax < bx ? ax : bx)) &&
               ((ay > by ? ay : by) >= (cy < dy ? cy : dy)) &&
               ((cy > dy ? cy : dy) >= (ay < by ? ay : by));
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         cr[k]  = X'(pa_ff[k]) - X'(pb_ff[k]);
         sgn[k] = {cr[k][X-1], cr[k] != '0};
      end
      if (sgn[0] == 2'b00 && sgn[1] == 2'b00) begin
         st3_in = ovl2_ff ? sip_pkg::ST_OVERLAP : sip_pkg::ST_NONE;
      end else if (sgn[0] != sgn[2] && sgn[1] != sgn[3]) begin
         st3_in = sip_pkg::ST_POINT;
      end else begin
         st3_in = sip_pkg::ST_NONE;
      end
   end

   always_comb begin
      num_abs_s = num3_ff[X-1] ? -num3_ff : num3_ff;
      den_abs_s = den3_ff[X-1] ? -den3_ff : den3_ff;
      dx_abs_s  = bax3_ff[D-1] ? -bax3_ff : bax3_ff;
      dy_abs_s  = bay3_ff[D-1] ? -bay3_ff : bay3_ff;
      num_mag   = num_abs_s[X-2:0];
      dx_mag    = dx_abs_s;
      dy_mag    = dy_abs_s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) begin
            ux_ff[k] <= ux_in[k];
            uy_ff[k] <= uy_in[k];
            wx_ff[k] <= wx_in[k];
            wy_ff[k] <= wy_in[k];
            pa_ff[k] <= ux_ff[k] * wy_ff[k];
            pb_ff[k] <= uy_ff[k] * wx_ff[k];
         end
         ax1_ff  <= ax;
         ay1_ff  <= ay;
         ovl1_ff <= ovl_in;
         bax2_ff <= ux_ff[5];
         bay2_ff <= uy_ff[5];
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         ovl2_ff <= ovl1_ff;
         st3_ff  <= st3_in;
         num3_ff <= cr[4];
         den3_ff <= cr[5];
         bax3_ff <= bax2_ff;
         bay3_ff <= bay2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         px_ff   <= (3*C+3)'(dx_mag) * (3*C+3)'(num_mag);
         py_ff   <= (3*C+3)'(dy_mag) * (3*C+3)'(num_mag);
         ue_ff   <= den_abs_s[RB-1:0];
         nx_ff   <= bax3_ff[D-1] ^ num3_ff[X-1] ^ den3_ff[X-1];
         ny_ff   <= bay3_ff[D-1] ^ num3_ff[X-1] ^ den3_ff[X-1];
         dz_ff   <= den3_ff == '0;
         st4_ff  <= st3_ff;
         ax4_ff  <= ax3_ff;
         ay4_ff  <= ay3_ff;
      end
   end

   assign status   = st4_ff;
   assign base_x   = ax4_ff;
   assign base_y   = ay4_ff;
   assign prod_x   = px_ff;
   assign prod_y   = py_ff;
   assign den_mag  = ue_ff;
   assign neg_x    = nx_ff;
   assign neg_y    = ny_ff;
   assign den_zero = dz_ff;
endmodule
`default_nettype wire

### sv/sip_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sip_div #(
   parameter int C = 16,
   parameter int F = 16
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [3*C+2:0]       dividend,
   input  wire logic [2*C+1:0]       divisor,
   output logic [C+F:0]              quotient
);
   localparam int D  = C + 1;
   localparam int Q  = D + F;
   localparam int RB = 2 * C + 2;

   logic [RB-1:0] r_ff [Q], r_in [Q], ue_ff [Q];
   logic [Q-1:0]  rq_ff [Q], rq_in [Q];
   logic [RB-1:0] r_prev, ue_prev;
   logic [Q-1:0]  rq_prev;
   logic [RB:0]   rs;
   logic          ge;

   always_comb begin
      r_prev  = RB'(dividend >> D);
      rq_prev = Q'(dividend) << F;
      ue_prev = divisor;
      for (int i = 0; i < Q; i++) begin
         rs       = {r_prev, rq_prev[Q-1]};
         ge       = rs >= {1'b0, ue_prev};
         r_in[i]  = ge ? RB'(rs - {1'b0, ue_prev}) : RB'(rs);
         rq_in[i] = {rq_prev[Q-2:0], ge};
         r_prev   = r_ff[i];
         rq_prev  = rq_ff[i];
         ue_prev  = ue_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ue_ff[0] <= divisor;
         for (int i = 0; i < Q; i++) begin
            r_ff[i]  <= r_in[i];
            rq_ff[i] <= rq_in[i];
         end
         for (int i = 1; i < Q; i++) begin
            ue_ff[i] <= ue_ff[i-1];
         end
      end
   end

   assign quotient = rq_ff[Q-1];
endmodule
`default_nettype wire

### sv/segment_intersection_point_unit.sv
// Top level of the segment intersection point unit.
//
//  channel | dir | handshake            | beat
//  req     | in  | req_tvalid/tready    | two segments, eight coordinates
//  rsp     | out | rsp_tvalid/tready    | status and fixed-point crossing
//
// A beat enters every cycle while req_tready is high; a beat passes through
// four front stages, one divider stage per quotient bit and the output register.
// Reset clears the valid bits only. When the output register holds a beat that is
// not taken, the whole pipeline holds and req_tready is low.
`default_nettype none
module segment_intersection_point_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  wire logic [8*COORD_BITS-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // status, cross_x, cross_y, zero fill
   output logic [sip_pkg::RSP_BITS-1:0]       rsp_tdata
);
   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int Q   = C + 1 + F;
   localparam int NV  = 4 + Q;
   localparam int PB  = sip_pkg::POINT_BITS;
   localparam int SW0 = (C + F > Q) ? C + F : Q;
   localparam int SW  = ((SW0 > PB) ? SW0 : PB) + 2;
   localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (PB - 1)) - SW'(1);
   localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (PB - 1));

   logic en;
   logic [NV-1:0] vld_ff;
   logic rsp_tvalid_ff;
   logic [sip_pkg::RSP_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   sip_pkg::status_type st_f, st_ff [Q];
   logic signed [C-1:0] bx_f, by_f, bx_ff [Q], by_ff [Q];
   logic [3*C+2:0] px_f, py_f;
   logic [2*C+1:0] ue_f;
   logic nx_f, ny_f, dz_f, nx_ff [Q], ny_ff [Q], dz_ff [Q];
   logic [Q-1:0] qx, qy;
   logic signed [SW-1:0] qx_s, qy_s, sx, sy;
   logic [PB-1:0] ox, oy;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   sip_front #(.C(C)) u_front (
      .clock(clock), .en(en), .coords(req_tdata), .status(st_f),
      .base_x(bx_f), .base_y(by_f), .prod_x(px_f), .prod_y(py_f),
      .den_mag(ue_f), .neg_x(nx_f), .neg_y(ny_f), .den_zero(dz_f)
   );

   sip_div #(.C(C), .F(F)) u_div_x (
      .clock(clock), .en(en), .dividend(px_f), .divisor(ue_f), .quotient(qx)
   );

   sip_div #(.C(C), .F(F)) u_div_y (
      .clock(clock), .en(en), .dividend(py_f), .divisor(ue_f), .quotient(qy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_f;
         bx_ff[0] <= bx_f;
         by_ff[0] <= by_f;
         nx_ff[0] <= nx_f;
         ny_ff[0] <= ny_f;
         dz_ff[0] <= dz_f;
         for (int i = 1; i < Q; i++) begin
            st_ff[i] <= st_ff[i-1];
            bx_ff[i] <= bx_ff[i-1];
            by_ff[i] <= by_ff[i-1];
            nx_ff[i] <= nx_ff[i-1];
            ny_ff[i] <= ny_ff[i-1];
            dz_ff[i] <= dz_ff[i-1];
         end
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   always_comb begin
      qx_s = dz_ff[Q-1] ? '0 : SW'(qx);
      qy_s = dz_ff[Q-1] ? '0 : SW'(qy);
      sx = (SW'(bx_ff[Q-1]) <<< F) + (nx_ff[Q-1] ? -qx_s : qx_s);
      sy = (SW'(by_ff[Q-1]) <<< F) + (ny_ff[Q-1] ? -qy_s : qy_s);
      if (sx > MAXV) ox = PB'(MAXV);
      else if (sx < MINV) ox = PB'(MINV);
      else ox = PB'(sx);
      if (sy > MAXV) oy = PB'(MAXV);
      else if (sy < MINV) oy = PB'(MINV);
      else oy = PB'(sy);
      if (st_ff[Q-1] != sip_pkg::ST_POINT) begin
         ox = '0;
         oy = '0;
      end
      rsp_tdata_in = sip_pkg::RSP_BITS'({oy, ox, st_ff[Q-1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[NV-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[NV-1];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("status code out of range");

   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != sip_pkg::ST_POINT |-> rsp_tdata[65:2] == '0)
      else $error("point fields set without a single point");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && vld_ff == '0)
      else $error("pipeline not empty after reset");
endmodule
`default_nettype wire
